/* design/hsp_pkg.sv */
// ----------------------------------------------------------------------------
// hsp_pkg
// Shared types and constants of the humidity sensor poller: channel widths,
// configuration record, sequencer phases and scaling constants.
// ----------------------------------------------------------------------------
package hsp_pkg;

  // Sizing
  parameter int TICK_COUNT_WIDTH = 24;
  parameter int RESPONSE_LENGTH  = 6;
  parameter int CFG_INDEX_WIDTH  = 3;
  parameter int CFG_DATA_WIDTH   = 24;
  parameter int WAIT_WIDTH       = 24;

  typedef logic [TICK_COUNT_WIDTH-1:0] tick_t;
  typedef logic [RESPONSE_LENGTH-1:0][7:0] resp_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_DEVICE_ADDRESS   = 3'd0,
    CFG_MEASURE_COMMAND  = 3'd1,
    CFG_TRIGGER_ARG_1ST  = 3'd2,
    CFG_TRIGGER_ARG_2ND  = 3'd3,
    CFG_CONVERSION_WAIT  = 3'd4,
    CFG_REPEAT_GAP       = 3'd5,
    CFG_POLL_ENABLE      = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [6:0]            device_address;
    logic [7:0]            measure_command;
    logic [7:0]            trigger_arg_first;
    logic [7:0]            trigger_arg_second;
    logic [WAIT_WIDTH-1:0] conversion_wait_ticks;
    logic [WAIT_WIDTH-1:0] repeat_gap_ticks;
    logic                  poll_enable;
  } hsp_cfg_t;

  // Reset values of the configuration registers
  parameter logic [6:0]            RST_DEVICE_ADDRESS  = 7'd56;
  parameter logic [7:0]            RST_MEASURE_COMMAND = 8'hAC;
  parameter logic [7:0]            RST_TRIGGER_ARG_1ST = 8'h33;
  parameter logic [7:0]            RST_TRIGGER_ARG_2ND = 8'h00;
  parameter logic [WAIT_WIDTH-1:0] RST_CONVERSION_WAIT = 24'd20000;
  parameter logic [WAIT_WIDTH-1:0] RST_REPEAT_GAP      = 24'd200000;
  parameter logic                  RST_POLL_ENABLE     = 1'b1;

  // Byte slot codes; after a transfer the slot register holds a done code
  parameter logic [2:0] SLOT_WRITE_ADDR = 3'd0;
  parameter logic [2:0] SLOT_COMMAND    = 3'd1;
  parameter logic [2:0] SLOT_ARG_1ST    = 3'd2;
  parameter logic [2:0] SLOT_LAST_ARG   = 3'd3;
  parameter logic [2:0] SLOT_READ_ADDR  = 3'd4;
  parameter logic [2:0] DONE_ERROR      = 3'd0;
  parameter logic [2:0] DONE_WRITE      = 3'd1;
  parameter logic [2:0] DONE_READ       = 3'd2;

  // Sequencer phases, one-hot
  typedef enum logic [19:0] {
    PH_START_A    = 20'h00001,
    PH_START_B    = 20'h00002,
    PH_START_C    = 20'h00004,
    PH_TX_SET     = 20'h00008,
    PH_TX_HIGH    = 20'h00010,
    PH_TX_LOW     = 20'h00020,
    PH_ACK_REL    = 20'h00040,
    PH_ACK_HIGH   = 20'h00080,
    PH_ACK_SAMPLE = 20'h00100,
    PH_RX_REL     = 20'h00200,
    PH_RX_HIGH    = 20'h00400,
    PH_RX_SAMPLE  = 20'h00800,
    PH_MACK_SET   = 20'h01000,
    PH_MACK_HIGH  = 20'h02000,
    PH_MACK_LOW   = 20'h04000,
    PH_STOP_B     = 20'h08000,
    PH_STOP_C     = 20'h10000,
    PH_STOP_D     = 20'h20000,
    PH_WAIT_CONV  = 20'h40000,
    PH_WAIT_GAP   = 20'h80000
  } phase_e;

  // Scaling
  parameter int          BUSY_BIT     = 7;
  parameter logic [6:0]  HUM_SCALE    = 7'd100;
  parameter logic [10:0] TEMP_SCALE   = 11'd2000;
  parameter logic [11:0] TEMP_OFFSET  = 12'd500;

  typedef struct packed {
    logic        busy;
    logic [6:0]  humidity;
    logic [10:0] temperature;
  } hsp_reading_t;

  typedef struct packed {
    logic               scl_release;
    logic               sda_release;
    logic [6:0]         humidity_percent;
    logic signed [11:0] temperature_tenths;
    logic               new_reading;
    logic               bus_error;
    logic               sensor_busy;
  } hsp_result_t;

endpackage

/* design/hsp_if.sv */
// ----------------------------------------------------------------------------
// hsp_if
// Valid/ready channels of the poller: tick input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface hsp_in_if;
  logic valid;
  logic ready;
  logic sda_sample;

  modport source (output valid, output sda_sample, input ready);
  modport sink   (input valid, input sda_sample, output ready);
endinterface

interface hsp_out_if;
  logic               valid;
  logic               ready;
  logic               scl_release;
  logic               sda_release;
  logic [6:0]         humidity_percent;
  logic signed [11:0] temperature_tenths;
  logic               new_reading;
  logic               bus_error;
  logic               sensor_busy;

  modport source (output valid, output scl_release, output sda_release,
                  output humidity_percent, output temperature_tenths,
                  output new_reading, output bus_error, output sensor_busy,
                  input ready);
  modport sink   (input valid, input scl_release, input sda_release,
                  input humidity_percent, input temperature_tenths,
                  input new_reading, input bus_error, input sensor_busy,
                  output ready);
endinterface

interface hsp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [hsp_pkg::CFG_INDEX_WIDTH-1:0] index;
  logic [hsp_pkg::CFG_DATA_WIDTH-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/hsp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// hsp_cfg_regs
// Configuration register file; takes one write word per cycle.
// ----------------------------------------------------------------------------
module hsp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  hsp_cfg_if.sink           cfg_i,
  output hsp_pkg::hsp_cfg_t cfg_o
);

  hsp_pkg::hsp_cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (hsp_pkg::cfg_idx_e'(cfg_i.index))
        hsp_pkg::CFG_DEVICE_ADDRESS:  cfg_d.device_address     = cfg_i.data[6:0];
        hsp_pkg::CFG_MEASURE_COMMAND: cfg_d.measure_command    = cfg_i.data[7:0];
        hsp_pkg::CFG_TRIGGER_ARG_1ST: cfg_d.trigger_arg_first  = cfg_i.data[7:0];
        hsp_pkg::CFG_TRIGGER_ARG_2ND: cfg_d.trigger_arg_second = cfg_i.data[7:0];
        hsp_pkg::CFG_CONVERSION_WAIT: begin
          cfg_d.conversion_wait_ticks = cfg_i.data[hsp_pkg::WAIT_WIDTH-1:0];
        end
        hsp_pkg::CFG_REPEAT_GAP: begin
          cfg_d.repeat_gap_ticks = cfg_i.data[hsp_pkg::WAIT_WIDTH-1:0];
        end
        hsp_pkg::CFG_POLL_ENABLE:     cfg_d.poll_enable        = cfg_i.data[0];
        default:                      cfg_d                    = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address        <= hsp_pkg::RST_DEVICE_ADDRESS;
      cfg_q.measure_command       <= hsp_pkg::RST_MEASURE_COMMAND;
      cfg_q.trigger_arg_first     <= hsp_pkg::RST_TRIGGER_ARG_1ST;
      cfg_q.trigger_arg_second    <= hsp_pkg::RST_TRIGGER_ARG_2ND;
      cfg_q.conversion_wait_ticks <= hsp_pkg::RST_CONVERSION_WAIT;
      cfg_q.repeat_gap_ticks      <= hsp_pkg::RST_REPEAT_GAP;
      cfg_q.poll_enable           <= hsp_pkg::RST_POLL_ENABLE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* design/hsp_scaler.sv */
// ----------------------------------------------------------------------------
// hsp_scaler
// Unpacks the six response bytes and scales the raw humidity to whole
// percent and the raw temperature to tenths of a degree above -50.0.
// ----------------------------------------------------------------------------
module hsp_scaler (
  input  hsp_pkg::resp_t       resp_i,
  output hsp_pkg::hsp_reading_t reading_o
);

  logic [19:0] hum_raw;
  logic [19:0] temp_raw;
  logic [26:0] hum_prod;
  logic [30:0] temp_prod;

  assign hum_raw  = {resp_i[1], resp_i[2], resp_i[3][7:4]};
  assign temp_raw = {resp_i[3][3:0], resp_i[4], resp_i[5]};

  // Full-scale raw value is 2^20: keep the top bits of the product
  assign hum_prod  = {7'd0, hum_raw} * {20'd0, hsp_pkg::HUM_SCALE};
  assign temp_prod = {11'd0, temp_raw} * {20'd0, hsp_pkg::TEMP_SCALE};

  assign reading_o.busy        = resp_i[0][hsp_pkg::BUSY_BIT];
  assign reading_o.humidity    = hum_prod[26:20];
  assign reading_o.temperature = temp_prod[30:20];

endmodule

/* design/hsp_sequencer.sv */
// ----------------------------------------------------------------------------
// hsp_sequencer
// Bus-phase sequencer: one phase per tick, drives the open-drain lines,
// collects the response and stores the scaled reading.
// ----------------------------------------------------------------------------
module hsp_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 sda_i,
  input  hsp_pkg::hsp_cfg_t    cfg_i,
  output hsp_pkg::hsp_result_t result_o
);

  hsp_pkg::phase_e      phase_q, phase_d;
  logic [3:0]           bit_cnt_q, bit_cnt_d;
  logic [2:0]           slot_q, slot_d;
  logic [7:0]           shift_q, shift_d;
  hsp_pkg::tick_t       tick_q, tick_d;
  logic [6:0]           hum_q, hum_d;
  logic [10:0]          temp_q, temp_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  hsp_pkg::resp_t       resp_q, resp_d;
  logic                 resp_we;
  logic [3:0]           bit_inc;
  logic [7:0]           rx_shift;
  logic                 load_en;
  logic [2:0]           load_slot;
  logic                 new_reading, bus_error, sensor_busy;
  hsp_pkg::hsp_reading_t reading;

  hsp_scaler u_scaler (
    .resp_i    (resp_q),
    .reading_o (reading)
  );

  function automatic logic [7:0] byte_for_slot(input hsp_pkg::hsp_cfg_t cfg,
                                               input logic [2:0] slot);
    logic [7:0] b;
    unique case (slot)
      hsp_pkg::SLOT_WRITE_ADDR: b = {cfg.device_address, 1'b0};
      hsp_pkg::SLOT_COMMAND:    b = cfg.measure_command;
      hsp_pkg::SLOT_ARG_1ST:    b = cfg.trigger_arg_first;
      hsp_pkg::SLOT_LAST_ARG:   b = cfg.trigger_arg_second;
      hsp_pkg::SLOT_READ_ADDR:  b = {cfg.device_address, 1'b1};
      default:                  b = 8'd0;
    endcase
    return b;
  endfunction

  assign bit_inc  = bit_cnt_q + 4'd1;
  assign rx_shift = {shift_q[6:0], sda_i};

  always_comb begin
    phase_d     = phase_q;
    bit_cnt_d   = bit_cnt_q;
    slot_d      = slot_q;
    shift_d     = shift_q;
    tick_d      = tick_q;
    hum_d       = hum_q;
    temp_d      = temp_q;
    scl_d       = scl_q;
    sda_d       = sda_q;
    resp_we     = 1'b0;
    load_en     = 1'b0;
    load_slot   = slot_q;
    new_reading = 1'b0;
    bus_error   = 1'b0;
    sensor_busy = 1'b0;

    if (!cfg_i.poll_enable) begin
      phase_d   = hsp_pkg::PH_START_A;
      bit_cnt_d = 4'd0;
      slot_d    = 3'd0;
      shift_d   = 8'd0;
      tick_d    = '0;
      scl_d     = 1'b1;
      sda_d     = 1'b1;
    end else begin
      unique case (phase_q)
        hsp_pkg::PH_START_A: begin
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          phase_d = hsp_pkg::PH_START_B;
        end
        hsp_pkg::PH_START_B: begin
          sda_d   = 1'b0;
          phase_d = hsp_pkg::PH_START_C;
        end
        hsp_pkg::PH_START_C: begin
          scl_d   = 1'b0;
          load_en = 1'b1;
        end
        hsp_pkg::PH_TX_SET: begin
          scl_d   = 1'b0;
          sda_d   = shift_q[7];
          phase_d = hsp_pkg::PH_TX_HIGH;
        end
        hsp_pkg::PH_TX_HIGH: begin
          scl_d   = 1'b1;
          phase_d = hsp_pkg::PH_TX_LOW;
        end
        hsp_pkg::PH_TX_LOW: begin
          scl_d     = 1'b0;
          shift_d   = {shift_q[6:0], 1'b0};
          bit_cnt_d = bit_inc;
          phase_d   = (bit_inc >= 4'd8) ? hsp_pkg::PH_ACK_REL : hsp_pkg::PH_TX_SET;
        end
        hsp_pkg::PH_ACK_REL: begin
          sda_d   = 1'b1;
          scl_d   = 1'b0;
          phase_d = hsp_pkg::PH_ACK_HIGH;
        end
        hsp_pkg::PH_ACK_HIGH: begin
          scl_d   = 1'b1;
          phase_d = hsp_pkg::PH_ACK_SAMPLE;
        end
        hsp_pkg::PH_ACK_SAMPLE: begin
          scl_d = 1'b0;
          priority if (sda_i) begin
            // slave nack: abort with a stop
            bus_error = 1'b1;
            slot_d    = hsp_pkg::DONE_ERROR;
            phase_d   = hsp_pkg::PH_STOP_B;
          end else if (slot_q == hsp_pkg::SLOT_READ_ADDR) begin
            slot_d  = 3'd0;
            phase_d = hsp_pkg::PH_RX_REL;
          end else if (slot_q >= hsp_pkg::SLOT_LAST_ARG) begin
            slot_d  = hsp_pkg::DONE_WRITE;
            phase_d = hsp_pkg::PH_STOP_B;
          end else begin
            load_en   = 1'b1;
            load_slot = slot_q + 3'd1;
          end
        end
        hsp_pkg::PH_RX_REL: begin
          sda_d     = 1'b1;
          scl_d     = 1'b0;
          bit_cnt_d = 4'd0;
          shift_d   = 8'd0;
          phase_d   = hsp_pkg::PH_RX_HIGH;
        end
        hsp_pkg::PH_RX_HIGH: begin
          scl_d   = 1'b1;
          phase_d = hsp_pkg::PH_RX_SAMPLE;
        end
        hsp_pkg::PH_RX_SAMPLE: begin
          scl_d     = 1'b0;
          shift_d   = rx_shift;
          bit_cnt_d = bit_inc;
          if (bit_inc >= 4'd8) begin
            resp_we = (slot_q < 3'(hsp_pkg::RESPONSE_LENGTH));
            phase_d = hsp_pkg::PH_MACK_SET;
          end else begin
            phase_d = hsp_pkg::PH_RX_HIGH;
          end
        end
        hsp_pkg::PH_MACK_SET: begin
          scl_d   = 1'b0;
          // no-ack after the last byte
          sda_d   = (slot_q >= 3'(hsp_pkg::RESPONSE_LENGTH - 1));
          phase_d = hsp_pkg::PH_MACK_HIGH;
        end
        hsp_pkg::PH_MACK_HIGH: begin
          scl_d   = 1'b1;
          phase_d = hsp_pkg::PH_MACK_LOW;
        end
        hsp_pkg::PH_MACK_LOW: begin
          scl_d = 1'b0;
          if (slot_q >= 3'(hsp_pkg::RESPONSE_LENGTH - 1)) begin
            slot_d  = hsp_pkg::DONE_READ;
            phase_d = hsp_pkg::PH_STOP_B;
          end else begin
            slot_d  = slot_q + 3'd1;
            phase_d = hsp_pkg::PH_RX_REL;
          end
        end
        hsp_pkg::PH_STOP_B: begin
          sda_d   = 1'b0;
          phase_d = hsp_pkg::PH_STOP_C;
        end
        hsp_pkg::PH_STOP_C: begin
          scl_d   = 1'b1;
          phase_d = hsp_pkg::PH_STOP_D;
        end
        hsp_pkg::PH_STOP_D: begin
          sda_d = 1'b1;
          if (slot_q == hsp_pkg::DONE_WRITE) begin
            tick_d  = hsp_pkg::tick_t'(cfg_i.conversion_wait_ticks);
            phase_d = hsp_pkg::PH_WAIT_CONV;
          end else begin
            if (slot_q == hsp_pkg::DONE_READ) begin
              if (reading.busy) begin
                sensor_busy = 1'b1;
              end else begin
                hum_d       = reading.humidity;
                temp_d      = reading.temperature;
                new_reading = 1'b1;
              end
            end
            tick_d  = hsp_pkg::tick_t'(cfg_i.repeat_gap_ticks);
            phase_d = hsp_pkg::PH_WAIT_GAP;
          end
        end
        hsp_pkg::PH_WAIT_CONV, hsp_pkg::PH_WAIT_GAP: begin
          if (tick_q == '0) begin
            slot_d  = (phase_q == hsp_pkg::PH_WAIT_CONV) ? hsp_pkg::SLOT_READ_ADDR
                                                         : hsp_pkg::SLOT_WRITE_ADDR;
            phase_d = hsp_pkg::PH_START_A;
          end else begin
            tick_d = tick_q - hsp_pkg::tick_t'(1);
          end
        end
        default: begin
          phase_d   = hsp_pkg::PH_START_A;
          bit_cnt_d = 4'd0;
          slot_d    = 3'd0;
          shift_d   = 8'd0;
          tick_d    = '0;
          scl_d     = 1'b1;
          sda_d     = 1'b1;
        end
      endcase

      if (load_en) begin
        slot_d    = load_slot;
        shift_d   = byte_for_slot(cfg_i, load_slot);
        bit_cnt_d = 4'd0;
        phase_d   = hsp_pkg::PH_TX_SET;
      end
    end
  end

  always_comb begin
    resp_d = resp_q;
    if (resp_we) begin
      resp_d[slot_q] = rx_shift;
    end
  end

  assign result_o.scl_release        = scl_d;
  assign result_o.sda_release        = sda_d;
  assign result_o.humidity_percent   = hum_d;
  assign result_o.temperature_tenths = $signed({1'b0, temp_d} - hsp_pkg::TEMP_OFFSET);
  assign result_o.new_reading        = new_reading;
  assign result_o.bus_error          = bus_error;
  assign result_o.sensor_busy        = sensor_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= hsp_pkg::PH_START_A;
      bit_cnt_q <= 4'd0;
      slot_q    <= 3'd0;
      shift_q   <= 8'd0;
      tick_q    <= '0;
      hum_q     <= 7'd0;
      temp_q    <= 11'd0;
      scl_q     <= 1'b1;
      sda_q     <= 1'b1;
    end else if (step_i) begin
      phase_q   <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      slot_q    <= slot_d;
      shift_q   <= shift_d;
      tick_q    <= tick_d;
      hum_q     <= hum_d;
      temp_q    <= temp_d;
      scl_q     <= scl_d;
      sda_q     <= sda_d;
    end
  end

  // Response bytes carry no reset: each is written before it is read
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      resp_q <= resp_d;
    end
  end

endmodule

/* design/humidity_sensor_i2c_poller.sv */
// ----------------------------------------------------------------------------
// humidity_sensor_i2c_poller
// Path: an accepted tick word is held in the input register; its result word
//   is stored in the output register once the output slot is free.
// Throughput: one tick word per cycle while results are taken; the sequencer
//   advances one bus phase per tick; one new tick can wait while a result waits.
// Reset: asynchronous, active low; lines released, sequence at start of the
//   write transfer, stored reading zero, configuration at its defaults.
// ----------------------------------------------------------------------------
module humidity_sensor_i2c_poller (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsp_in_if.sink    sample_i,
  hsp_out_if.source result_o,
  hsp_cfg_if.sink   cfg_i
);

  // Input register: one sampled SDA word
  logic in_valid_q, in_valid_d;
  logic in_sda_q;

  // Output register: one result word
  logic                 out_valid_q, out_valid_d;
  hsp_pkg::hsp_result_t out_q;
  hsp_pkg::hsp_result_t step_result;

  hsp_pkg::hsp_cfg_t cfg;
  logic              advance;
  logic              in_take;

  hsp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Advance the sequencer when a tick is held and the output slot is free
  // or being emptied this cycle.
  assign advance        = in_valid_q && (!out_valid_q || result_o.ready);
  assign sample_i.ready = !in_valid_q || advance;
  assign in_take        = sample_i.valid && sample_i.ready;

  hsp_sequencer u_sequencer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .sda_i    (in_sda_q),
    .cfg_i    (cfg),
    .result_o (step_result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold the word until the next load
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_sda_q <= sample_i.sda_sample;
    end
    if (advance) begin
      out_q <= step_result;
    end
  end

  // Drive the result channel straight from the output register
  assign result_o.valid              = out_valid_q;
  assign result_o.scl_release        = out_q.scl_release;
  assign result_o.sda_release        = out_q.sda_release;
  assign result_o.humidity_percent   = out_q.humidity_percent;
  assign result_o.temperature_tenths = out_q.temperature_tenths;
  assign result_o.new_reading        = out_q.new_reading;
  assign result_o.bus_error          = out_q.bus_error;
  assign result_o.sensor_busy        = out_q.sensor_busy;

endmodule

/* design/hsp_checker.sv */
// ----------------------------------------------------------------------------
// hsp_checker
// Port-level checks of the poller, attached to the top level by bind.
// ----------------------------------------------------------------------------
module hsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        scl_i,
  input logic        sda_i,
  input logic [6:0]  hum_i,
  input logic [11:0] temp_i,
  input logic        new_reading_i,
  input logic        bus_error_i,
  input logic        sensor_busy_i
);

  // Hold a stalled result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({scl_i, sda_i, hum_i, temp_i, new_reading_i, bus_error_i, sensor_busy_i}))
    else $error("stalled result word changed");

  // At most one event flag per result word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $onehot0({new_reading_i, bus_error_i, sensor_busy_i}))
    else $error("more than one event flag set");

  // Evaluation happens on the last stop tick: both lines released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (new_reading_i || sensor_busy_i) |-> scl_i && sda_i)
    else $error("reading reported with a line pulled low");

  // A nack is seen on the sampling tick, which pulls SCL low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bus_error_i |-> !scl_i)
    else $error("bus error reported with SCL released");

  // The configuration port never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind humidity_sensor_i2c_poller hsp_checker u_hsp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_i.valid),
  .cfg_ready_i   (cfg_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .scl_i         (result_o.scl_release),
  .sda_i         (result_o.sda_release),
  .hum_i         (result_o.humidity_percent),
  .temp_i        (result_o.temperature_tenths),
  .new_reading_i (result_o.new_reading),
  .bus_error_i   (result_o.bus_error),
  .sensor_busy_i (result_o.sensor_busy)
);
